### hw/rtl/eqdb_pkg.sv
// ----------------------------------------------------------------------------
// eqdb_pkg
// Shared types and constants for the encoder queue descriptor builder.
// ----------------------------------------------------------------------------
package eqdb_pkg;

  // ring size in bytes, a power of two no larger than the offset range
  localparam int RING_BYTES = 4194304;
  localparam int DESC_SLOTS = 32;

  localparam int ENTRY_BITS = 32;
  localparam int OFF_BITS   = 24;
  localparam int CH_BITS    = 5;
  localparam int NUM_CH     = 32;
  localparam int FTYPE_BITS = 2;
  localparam int CSIZE_BITS = 20;
  localparam int GOP_BITS   = 8;
  localparam int CNT_BITS   = 6;
  localparam int STAT_BITS  = 3;
  localparam int SLOT_BITS  = $clog2(DESC_SLOTS);

  // entry word layout
  localparam int CH_LSB    = 24;
  localparam int FTYPE_LSB = 29;

  localparam logic [OFF_BITS:0]   RING_SPAN = (OFF_BITS + 1)'(RING_BYTES);
  localparam logic [OFF_BITS-1:0] RING_MASK = OFF_BITS'(RING_SPAN - 1'b1);

  // code size rounding: add header pad, clear the low five bits
  localparam int ROUND_BITS = CSIZE_BITS + 1;
  localparam logic [ROUND_BITS-1:0] ROUND_PAD  = ROUND_BITS'(64 + 32);
  localparam logic [ROUND_BITS-1:0] ROUND_MASK = ~ROUND_BITS'(31);

  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(DESC_SLOTS - 1);

  localparam int IN_DATA_BITS   = ((2 * ENTRY_BITS + CSIZE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = CH_BITS + FTYPE_BITS + 2 * OFF_BITS + SLOT_BITS + 1
                                  + GOP_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [FTYPE_BITS-1:0] FRAME_I = '0;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_ACCEPTED      = 3'd0,
    STAT_NO_LISTENER   = 3'd1,
    STAT_WRAP_MISMATCH = 3'd2,
    STAT_AWAIT_I       = 3'd3,
    STAT_BAD_CHANNEL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_LISTENER_MASK = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_DEFAULT_GOP   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_CH-1:0]   listener_mask;
    logic [CNT_BITS-1:0] channel_count;
    logic [GOP_BITS-1:0] default_gop;
  } cfg_t;

  typedef struct packed {
    logic               set_pending;
    logic               clr_pending;
    logic               adv_slot;
    logic [CH_BITS-1:0] ch;
  } state_upd_t;

  typedef struct packed {
    status_t               status;
    logic [CH_BITS-1:0]    channel;
    logic [FTYPE_BITS-1:0] frame_type;
    logic [OFF_BITS-1:0]   offset;
    logic [OFF_BITS-1:0]   byte_count;
    logic [SLOT_BITS-1:0]  slot;
    logic                  gop_write;
    logic [GOP_BITS-1:0]   gop_value;
  } result_t;

endpackage

### hw/rtl/eqdb_cfg_regs.sv
// ----------------------------------------------------------------------------
// eqdb_cfg_regs
// Configuration registers: listener mask, channel count and default GOP.
// ----------------------------------------------------------------------------
module eqdb_cfg_regs
  import eqdb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [ENTRY_BITS-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listener_mask <= '0;
      cfg.channel_count <= CNT_BITS'(16);
      cfg.default_gop   <= GOP_BITS'(30);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LISTENER_MASK: cfg.listener_mask <= cfg_data[NUM_CH-1:0];
        CFG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[CNT_BITS-1:0];
        CFG_DEFAULT_GOP:   cfg.default_gop   <= cfg_data[GOP_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/eqdb_gop_state.sv
// ----------------------------------------------------------------------------
// eqdb_gop_state
// Per-channel GOP reset flags and the descriptor write pointer.
// ----------------------------------------------------------------------------
module eqdb_gop_state
  import eqdb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CH_BITS-1:0]   lookup_ch,
  output logic                 pending,
  output logic [SLOT_BITS-1:0] write_slot,
  input  logic                 commit,
  input  state_upd_t           upd
);

  logic [NUM_CH-1:0] gop_reset_pending;

  assign pending = gop_reset_pending[lookup_ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      gop_reset_pending <= '0;
      write_slot        <= '0;
    end else if (commit) begin
      if (upd.set_pending) begin
        gop_reset_pending[upd.ch] <= 1'b1;
      end else if (upd.clr_pending) begin
        gop_reset_pending[upd.ch] <= 1'b0;
      end
      if (upd.adv_slot) begin
        write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/eqdb_classify.sv
// ----------------------------------------------------------------------------
// eqdb_classify
// Field extraction, ring length, wrap check and the accept/drop decision.
// ----------------------------------------------------------------------------
module eqdb_classify
  import eqdb_pkg::*;
(
  input  logic [ENTRY_BITS-1:0] current_entry,
  input  logic [ENTRY_BITS-1:0] next_entry,
  input  logic [CSIZE_BITS-1:0] code_size,
  input  cfg_t                  cfg,
  input  logic                  pending,
  input  logic [SLOT_BITS-1:0]  write_slot,
  output logic [CH_BITS-1:0]    ch,
  output result_t               res,
  output state_upd_t            upd
);

  logic [FTYPE_BITS-1:0] ftype;
  logic [OFF_BITS-1:0]   cur_off;
  logic [OFF_BITS-1:0]   nxt_off;
  logic [OFF_BITS-1:0]   len;
  logic [ROUND_BITS-1:0] rounded;
  logic                  bad_ch;
  logic                  no_listener;
  logic                  mismatch;

  assign ch      = current_entry[CH_LSB +: CH_BITS];
  assign ftype   = current_entry[FTYPE_LSB +: FTYPE_BITS];
  assign cur_off = current_entry[OFF_BITS-1:0];
  assign nxt_off = next_entry[OFF_BITS-1:0];

  // distance modulo the ring
  assign len     = (nxt_off - cur_off) & RING_MASK;
  assign rounded = (ROUND_BITS'(code_size) + ROUND_PAD) & ROUND_MASK;

  assign bad_ch      = CNT_BITS'(ch) >= cfg.channel_count;
  assign no_listener = !cfg.listener_mask[ch];
  assign mismatch    = (cur_off > nxt_off) && (len != OFF_BITS'(rounded));

  always_comb begin
    res.status     = STAT_ACCEPTED;
    res.channel    = ch;
    res.frame_type = ftype;
    res.offset     = cur_off;
    res.byte_count = len;
    res.slot       = '0;
    res.gop_write  = 1'b0;
    res.gop_value  = '0;
    upd.set_pending = 1'b0;
    upd.clr_pending = 1'b0;
    upd.adv_slot    = 1'b0;
    upd.ch          = ch;
    priority if (bad_ch) begin
      res.status = STAT_BAD_CHANNEL;
    end else if (no_listener) begin
      res.status = STAT_NO_LISTENER;
    end else if (mismatch) begin
      res.status      = STAT_WRAP_MISMATCH;
      res.gop_write   = 1'b1;
      res.gop_value   = GOP_BITS'(1);
      upd.set_pending = 1'b1;
    end else if (pending && ftype != FRAME_I) begin
      res.status = STAT_AWAIT_I;
    end else begin
      // an I frame closes an armed reset
      if (pending) begin
        res.gop_write   = 1'b1;
        res.gop_value   = cfg.default_gop;
        upd.clr_pending = 1'b1;
      end
      res.slot     = write_slot;
      upd.adv_slot = 1'b1;
    end
  end

endmodule

### hw/rtl/encoder_queue_descriptor_builder.sv
// ----------------------------------------------------------------------------
// encoder_queue_descriptor_builder
// Turns encoder completion-queue entries into frame descriptors.
// ----------------------------------------------------------------------------
// Takes one queue entry per clock while the output is not stalled and
// returns exactly one result per entry. The entry is captured in an input
// register, classified in one pass of logic (field extraction, ring
// distance, wrap check, per-channel GOP flag lookup) and written to the result
// register, so a new entry can follow every cycle when the output is free;
// the input side keeps taking entries while one result waits, until both
// registers are full. The 32 per-channel GOP reset flags and the descriptor
// write pointer live in flip-flops and clear on reset. The ring size must be
// a power of two. Configuration writes are always taken and should only be
// issued while no entry is in flight.
module encoder_queue_descriptor_builder
  import eqdb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // current_entry, next_entry, code_size
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // channel, frame_type, offset, byte_count, slot, gop_write, gop_value
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // status
  output logic [STAT_BITS-1:0]     m_axis_tuser,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [ENTRY_BITS-1:0]    cfg_data
);

  cfg_t                  cfg;
  logic                  in_valid;
  logic [ENTRY_BITS-1:0] in_cur;
  logic [ENTRY_BITS-1:0] in_next;
  logic [CSIZE_BITS-1:0] in_csize;
  logic                  advance;
  logic [CH_BITS-1:0]    ch;
  logic                  pending;
  logic [SLOT_BITS-1:0]  write_slot;
  result_t               res;
  result_t               out_res;
  state_upd_t            upd;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cur   <= s_axis_tdata[ENTRY_BITS-1:0];
      in_next  <= s_axis_tdata[ENTRY_BITS +: ENTRY_BITS];
      in_csize <= s_axis_tdata[2*ENTRY_BITS +: CSIZE_BITS];
    end
  end

  eqdb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eqdb_gop_state u_state (
    .clk        (clk),
    .rst        (rst),
    .lookup_ch  (ch),
    .pending    (pending),
    .write_slot (write_slot),
    .commit     (advance),
    .upd        (upd)
  );

  eqdb_classify u_classify (
    .current_entry (in_cur),
    .next_entry    (in_next),
    .code_size     (in_csize),
    .cfg           (cfg),
    .pending       (pending),
    .write_slot    (write_slot),
    .ch            (ch),
    .res           (res),
    .upd           (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = OUT_DATA_BITS'({out_res.gop_value, out_res.gop_write, out_res.slot,
                                        out_res.byte_count, out_res.offset,
                                        out_res.frame_type, out_res.channel});

endmodule

### bench/tb_encoder_queue_descriptor_builder.sv
// ----------------------------------------------------------------------------
// tb_encoder_queue_descriptor_builder
// Self-checking bench for the encoder queue descriptor builder. Queue entries
// go in on the input stream and one descriptor comes back per entry. A
// software copy of the channel GOP reset flags and the slot pointer works out
// each expected descriptor when its request is taken. Descriptors are checked
// in order, field by field, over several listener and channel settings and
// under random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_encoder_queue_descriptor_builder
  import eqdb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // expected descriptors, worked out from the channel state at request time
  class descriptor_book;
    logic [NUM_CH-1:0]   listener_mask;
    logic [CNT_BITS-1:0] channel_count;
    logic [GOP_BITS-1:0] default_gop;
    bit                  gop_reset_armed [NUM_CH];
    int unsigned         write_slot;
    result_t             awaited [$];
    int unsigned         errors;

    function new();
      listener_mask = '0;
      channel_count = CNT_BITS'(16);
      default_gop   = GOP_BITS'(30);
      foreach (gop_reset_armed[i]) gop_reset_armed[i] = 1'b0;
      write_slot = 0;
      errors     = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [ENTRY_BITS-1:0] value);
      unique case (idx)
        CFG_LISTENER_MASK: listener_mask = value;
        CFG_CHANNEL_COUNT: channel_count = value[CNT_BITS-1:0];
        CFG_DEFAULT_GOP:   default_gop = value[GOP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_entry(logic [ENTRY_BITS-1:0] cur_word, logic [ENTRY_BITS-1:0] nxt_word,
                             logic [CSIZE_BITS-1:0] csize);
      result_t             d;
      logic [OFF_BITS-1:0] cur_off;
      logic [OFF_BITS-1:0] nxt_off;
      logic [CH_BITS-1:0]  ch;
      int unsigned         span;
      int unsigned         rounded;
      cur_off = cur_word[OFF_BITS-1:0];
      nxt_off = nxt_word[OFF_BITS-1:0];
      ch      = cur_word[CH_LSB +: CH_BITS];
      span    = ((nxt_off % RING_BYTES) + RING_BYTES - (cur_off % RING_BYTES)) % RING_BYTES;
      rounded = (int'(csize) + 96) & ~32'd31;
      d            = '0;
      d.status     = STAT_ACCEPTED;
      d.channel    = ch;
      d.frame_type = cur_word[FTYPE_LSB +: FTYPE_BITS];
      d.offset     = cur_off;
      d.byte_count = span[OFF_BITS-1:0];
      if (ch >= channel_count) begin
        d.status = STAT_BAD_CHANNEL;
      end else if (!listener_mask[ch]) begin
        d.status = STAT_NO_LISTENER;
      end else if (cur_off > nxt_off && span != rounded) begin
        gop_reset_armed[ch] = 1'b1;
        d.status    = STAT_WRAP_MISMATCH;
        d.gop_write = 1'b1;
        d.gop_value = GOP_BITS'(1);
      end else if (gop_reset_armed[ch] && d.frame_type != FRAME_I) begin
        d.status = STAT_AWAIT_I;
      end else begin
        if (gop_reset_armed[ch]) begin
          gop_reset_armed[ch] = 1'b0;
          d.gop_write = 1'b1;
          d.gop_value = default_gop;
        end
        d.slot     = write_slot[SLOT_BITS-1:0];
        write_slot = (write_slot + 1) % DESC_SLOTS;
      end
      awaited.push_back(d);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_descriptor(logic [OUT_DATA_BITS-1:0] data, logic [STAT_BITS-1:0] user);
      result_t               d;
      logic [CH_BITS-1:0]    ch;
      logic [FTYPE_BITS-1:0] ft;
      logic [OFF_BITS-1:0]   off;
      logic [OFF_BITS-1:0]   cnt;
      logic [SLOT_BITS-1:0]  sl;
      logic                  gw;
      logic [GOP_BITS-1:0]   gv;
      if (awaited.size() == 0) begin
        errors++;
        $error("descriptor with no request outstanding: status %0d data %h", user, data);
        return;
      end
      d = awaited.pop_front();
      {gv, gw, sl, cnt, off, ft, ch} = data[OUT_FIELD_BITS-1:0];
      compare_field("status", d.status, user);
      compare_field("channel", d.channel, ch);
      compare_field("frame_type", d.frame_type, ft);
      compare_field("offset", d.offset, off);
      compare_field("byte_count", d.byte_count, cnt);
      compare_field("slot", d.slot, sl);
      compare_field("gop_write", d.gop_write, gw);
      compare_field("gop_value", d.gop_value, gv);
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [STAT_BITS-1:0]     m_axis_tuser;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [ENTRY_BITS-1:0]    cfg_data;

  descriptor_book book = new();
  int unsigned    send_gap_pct;
  int unsigned    recv_stall_pct;

  encoder_queue_descriptor_builder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      book.check_descriptor(m_axis_tdata, m_axis_tuser);
    end
  end

  function automatic logic [ENTRY_BITS-1:0] make_entry(int unsigned ch, int unsigned ftype,
                                                     logic [OFF_BITS-1:0] off);
    return {1'b0, FTYPE_BITS'(ftype), CH_BITS'(ch), off};
  endfunction

  task automatic write_register(cfg_reg_t idx, logic [ENTRY_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    book.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [ENTRY_BITS-1:0] mask, int unsigned count, int unsigned gop);
    write_register(CFG_LISTENER_MASK, mask);
    write_register(CFG_CHANNEL_COUNT, count);
    write_register(CFG_DEFAULT_GOP, gop);
  endtask

  task automatic send_entry(logic [ENTRY_BITS-1:0] cur_word, logic [ENTRY_BITS-1:0] nxt_word,
                            logic [CSIZE_BITS-1:0] csize);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'({csize, nxt_word, cur_word});
    do @(posedge clk); while (!s_axis_tready);
    book.note_entry(cur_word, nxt_word, csize);
  endtask

  // close the burst and let every outstanding descriptor come back
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_entry();
    int unsigned           kind;
    int unsigned           ch;
    int unsigned           ftype;
    int unsigned           lim;
    int unsigned           span;
    int unsigned           lead;
    logic [OFF_BITS-1:0]   cur_off;
    logic [OFF_BITS-1:0]   nxt_off;
    logic [CSIZE_BITS-1:0] csize;
    logic [ENTRY_BITS-1:0] cur_word;
    logic [ENTRY_BITS-1:0] nxt_word;
    lim = (book.channel_count > NUM_CH) ? NUM_CH : book.channel_count;
    if (lim > 6) lim = 6;
    // keep most traffic on a few live channels so reset sequences play out
    if (lim > 0 && $urandom_range(99) < 75) ch = $urandom_range(lim - 1);
    else ch = $urandom_range(NUM_CH - 1);
    ftype = ($urandom_range(99) < 30) ? 0 : $urandom_range(3, 1);
    kind  = $urandom_range(99);
    if (kind < 40) begin
      cur_off = OFF_BITS'($urandom_range(RING_BYTES - 1));
      if ($urandom_range(9) == 0) cur_off[OFF_BITS-1 -: 2] = 2'($urandom_range(3));
      nxt_off = OFF_BITS'(cur_off + $urandom_range(200000));
      csize   = CSIZE_BITS'($urandom_range(200000));
    end else begin
      // frame that wraps the ring end; length a multiple of 32
      span    = 32 * $urandom_range(32000, 3);
      lead    = $urandom_range(span - 1, 1);
      cur_off = OFF_BITS'(RING_BYTES - lead);
      nxt_off = OFF_BITS'(span - lead);
      if (kind < 62) csize = CSIZE_BITS'(span - 96 + $urandom_range(31));
      else csize = CSIZE_BITS'($urandom);
    end
    cur_word = make_entry(ch, ftype, cur_off);
    cur_word[ENTRY_BITS-1] = 1'($urandom_range(1));
    nxt_word = {8'($urandom_range(255)), nxt_off};
    if (kind >= 90) begin
      cur_word = $urandom;
      nxt_word = $urandom;
      csize    = CSIZE_BITS'($urandom);
    end
    send_entry(cur_word, nxt_word, csize);
  endtask

  task automatic run_segment(logic [ENTRY_BITS-1:0] mask, int unsigned count,
                             int unsigned gop);
    configure(mask, count, gop);
    repeat (290) send_random_entry();
    settle();
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_LISTENER_MASK;
    cfg_data       = '0;
    send_gap_pct   = 27;
    recv_stall_pct = 59;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings out of reset: no listeners, sixteen channels
    send_entry(make_entry(2, 0, 24'h000000), 32'h0000_0100, '0);
    send_entry(make_entry(20, 0, 24'h000000), 32'h0000_0100, '0);
    settle();

    configure(32'hFFFF_FFFF, 32, 255);
    send_entry(make_entry(0, 0, 24'h000000), 32'h0000_0100, '0);
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    // wrap mismatch arms the reset, non-I frames wait for an I frame
    send_entry(make_entry(3, 1, 24'h3FFF00), 32'h0000_0100, '0);
    send_entry(make_entry(3, 1, 24'h000100), 32'h0000_0200, '0);
    send_entry(make_entry(3, 2, 24'h3FFF00), 32'h0000_0100, '0);
    send_entry(make_entry(3, 3, 24'h000100), 32'h0000_0300, '0);
    send_entry(make_entry(3, 0, 24'h000100), 32'h0000_0300, '0);
    // wrapped frame of 512 bytes against code sizes at the rounding edges
    send_entry(make_entry(5, 2, 24'h3FFF00), 32'h0000_0100, 20'd416);
    send_entry(make_entry(5, 2, 24'h3FFF00), 32'h0000_0100, 20'd447);
    send_entry(make_entry(5, 2, 24'h3FFF00), 32'h0000_0100, 20'd448);
    send_entry(make_entry(5, 0, 24'h3FFF00), 32'h0000_0100, '0);
    send_entry(make_entry(5, 0, 24'h000400), 32'h0000_0500, '0);
    // offsets beyond the ring size
    send_entry(make_entry(7, 1, 24'hC00010), 32'h0000_0020, '0);
    send_entry(make_entry(8, 1, 24'h400000), 32'h003F_FFFF, '0);
    send_entry(make_entry(9, 1, 24'h000010), 32'h00FF_FFF0, 20'hFFFFF);
    send_entry(make_entry(10, 0, 24'h123456), 32'hAB12_3456, '0);
    settle();

    configure(32'h0000_0001, 1, 1);
    send_entry(make_entry(0, 1, 24'h000000), 32'h0000_0040, '0);
    send_entry(make_entry(1, 0, 24'h000000), 32'h0000_0040, '0);
    settle();

    // no channel present, then every channel present
    configure(32'h8000_0000, 0, 0);
    send_entry(make_entry(0, 0, 24'h000000), 32'h0000_0040, '0);
    settle();
    write_register(CFG_CHANNEL_COUNT, 63);
    send_entry(make_entry(31, 0, 24'h3FFF00), 32'h0000_0100, '0);
    send_entry(make_entry(31, 0, 24'h000100), 32'h0000_0140, '0);
    send_entry(make_entry(30, 0, 24'h000100), 32'h0000_0140, '0);
    settle();

    send_gap_pct   = 27;
    recv_stall_pct = 59;
    run_segment(32'hFFFF_FFFF, 32, 30);
    run_segment($urandom | 32'h0000_000F, 8, 255);

    send_gap_pct   = 59;
    recv_stall_pct = 27;
    run_segment(32'hFFFF_FFFF, 1, 1);
    run_segment($urandom, 32, 17);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_segment(32'hFFFF_FFFF, 63, 200);
    run_segment($urandom | 32'hFFFF_FF00, 20, 128);

    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
